### src/pnmu_pkg.sv
package pnmu_pkg;

  localparam int MAX_MEASUREMENTS_DEF = 64;
  localparam int COMPONENT_WIDTH_DEF  = 20;
  localparam int WEIGHT_WIDTH         = 22;
  localparam int INDEX_WIDTH          = 6;
  localparam int RATE_WIDTH           = 9;
  localparam int MAXD_WIDTH           = 19;
  localparam int CFG_INDEX_WIDTH      = 2;
  localparam int CFG_DATA_WIDTH       = 32;
  localparam int DSQ_WIDTH            = 64;
  localparam int ROOT_WIDTH           = 32;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MOVE_RATE     = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WEIGHT_ENABLE = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_DISTANCE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_FETCH,
    ST_SQRT,
    ST_BLEND,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic do_clear;
    logic do_append;
    logic scan_rd;   // issue store read at scan index
    logic scan_acc;  // fold registered read into running minimum
    logic best_rd;   // read winning entry
    logic sqrt_init;
    logic sqrt_step;
    logic blend;     // one component per cycle
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic act_clear;
    logic act_append;
    logic act_update;
    logic empty;
    logic scan_last; // read index is one past the last valid entry
    logic sqrt_done;
    logic blend_done;
  } stat_t;

endpackage

### src/pnmu_ctrl.sv
module pnmu_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  pnmu_pkg::stat_t stat,
  output pnmu_pkg::cmd_t  cmd
);

  pnmu_pkg::state_t state_r, state_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             ovalid_r, ovalid_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pnmu_pkg::ST_IDLE;
      rd_pend_r <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;

  // sequence one item at a time
  always_comb begin
    state_nxt   = state_r;
    rd_pend_nxt = 1'b0;
    ovalid_nxt  = ovalid_r && !out_tready;
    cmd         = '0;
    in_tready   = 1'b0;
    case (state_r)
      pnmu_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = pnmu_pkg::ST_READ;
        end
      end
      pnmu_pkg::ST_READ: begin
        if (stat.act_clear) begin
          cmd.do_clear = 1'b1;
          state_nxt    = pnmu_pkg::ST_IDLE;
        end else if (stat.act_append) begin
          cmd.do_append = 1'b1;
          state_nxt     = pnmu_pkg::ST_IDLE;
        end else if (stat.act_update) begin
          if (stat.empty) begin
            state_nxt = pnmu_pkg::ST_OUT;
          end else begin
            cmd.scan_rd = 1'b1;
            rd_pend_nxt = 1'b1;
            state_nxt   = pnmu_pkg::ST_SCAN;
          end
        end else begin
          state_nxt = pnmu_pkg::ST_IDLE;
        end
      end
      pnmu_pkg::ST_SCAN: begin
        cmd.scan_acc = rd_pend_r;
        if (!stat.scan_last) begin
          cmd.scan_rd = 1'b1;
          rd_pend_nxt = 1'b1;
        end else if (!rd_pend_r) begin
          cmd.best_rd = 1'b1;
          state_nxt   = pnmu_pkg::ST_FETCH;
        end
      end
      pnmu_pkg::ST_FETCH: begin
        cmd.sqrt_init = 1'b1;
        state_nxt     = pnmu_pkg::ST_SQRT;
      end
      pnmu_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_done) state_nxt = pnmu_pkg::ST_BLEND;
      end
      pnmu_pkg::ST_BLEND: begin
        cmd.blend = 1'b1;
        if (stat.blend_done) state_nxt = pnmu_pkg::ST_OUT;
      end
      pnmu_pkg::ST_OUT: begin
        if (!ovalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          ovalid_nxt   = 1'b1;
          state_nxt    = pnmu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pnmu_pkg::ST_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == pnmu_pkg::ST_IDLE)
    else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!ovalid_r || out_tready))
    else $error("result overwritten");
  a_load_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == pnmu_pkg::ST_READ)
    else $error("load not followed by decode");

endmodule

### src/pnmu_datapath.sv
module pnmu_datapath #(
  parameter int MAX_MEASUREMENTS = pnmu_pkg::MAX_MEASUREMENTS_DEF,
  parameter int COMPONENT_WIDTH  = pnmu_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pnmu_pkg::cmd_t                       cmd,
  output pnmu_pkg::stat_t                      stat,
  input  logic [1:0]                           in_action,
  input  logic signed [3:0][COMPONENT_WIDTH-1:0] in_vec,
  input  logic signed [pnmu_pkg::WEIGHT_WIDTH-1:0] in_weight,
  input  logic [pnmu_pkg::RATE_WIDTH-1:0]      move_rate,
  input  logic                                 weight_enable,
  input  logic [pnmu_pkg::MAXD_WIDTH-1:0]      max_distance,
  output logic [3:0][COMPONENT_WIDTH-1:0]      res_vec,
  output logic [pnmu_pkg::WEIGHT_WIDTH-1:0]    res_weight,
  output logic [pnmu_pkg::INDEX_WIDTH-1:0]     res_index,
  output logic                                 res_empty,
  output logic                                 res_dropped
);

  localparam int AW  = (MAX_MEASUREMENTS > 1) ? $clog2(MAX_MEASUREMENTS) : 1;
  localparam int CW  = $clog2(MAX_MEASUREMENTS + 1);
  localparam int MW  = 4 * COMPONENT_WIDTH;
  localparam int DW  = COMPONENT_WIDTH + 1;
  localparam int DSQ = pnmu_pkg::DSQ_WIDTH;
  localparam int RW  = pnmu_pkg::ROOT_WIDTH;
  localparam int PW  = DW + pnmu_pkg::RATE_WIDTH + 1;
  localparam int WW  = pnmu_pkg::WEIGHT_WIDTH;
  localparam logic [CW-1:0] CAP = CW'(MAX_MEASUREMENTS);
  localparam logic signed [DW+1:0] CMAX = (DW+2)'((64'sd1 <<< (COMPONENT_WIDTH-1)) - 1);
  localparam logic signed [DW+1:0] CMIN = -(DW+2)'(64'sd1 <<< (COMPONENT_WIDTH-1));

  logic [MW-1:0] mem [MAX_MEASUREMENTS];
  logic [MW-1:0] rd_data_r;
  logic [CW-1:0] count_r;
  logic          sticky_r;
  logic [1:0]    act_r;
  logic signed [3:0][COMPONENT_WIDTH-1:0] vec_r;
  logic signed [WW-1:0] wt_r;
  logic [CW-1:0] rd_idx_r;
  logic [AW-1:0] acc_idx_r, best_idx_r;
  logic          first_r;
  logic [DSQ-1:0] best_d_r;
  logic [DSQ-1:0] sq_rem_r;
  logic [DSQ-1:0] sq_root_r;
  logic [5:0]     sq_cnt_r;
  logic [1:0]     bl_k_r;
  logic signed [3:0][COMPONENT_WIDTH-1:0] blend_r;
  logic [DSQ-1:0] dist_c;

  // store the appended vector, read entries for the scan and the fetch
  always_ff @(posedge clk) begin
    if (cmd.do_append && count_r < CAP)
      mem[count_r[AW-1:0]] <= vec_r;
    if (cmd.scan_rd)
      rd_data_r <= mem[rd_idx_r[AW-1:0]];
    else if (cmd.best_rd)
      rd_data_r <= mem[best_idx_r];
  end

  // track fill count and dropped appends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sticky_r <= 1'b0;
    end else if (cmd.do_clear) begin
      count_r  <= '0;
      sticky_r <= 1'b0;
    end else if (cmd.do_append) begin
      if (count_r < CAP) count_r <= count_r + 1'b1;
      else               sticky_r <= 1'b1;
    end
  end

  // capture input beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      vec_r <= in_vec;
      wt_r  <= in_weight;
    end
  end

  // squared distance of the registered entry, saturating
  always_comb begin
    logic signed [DW-1:0] d;
    logic [DW-1:0]        a;
    logic [DSQ+1:0]       s;
    s = '0;
    for (int k = 0; k < 4; k++) begin
      d = DW'($signed(vec_r[k])) -
          DW'($signed(rd_data_r[k*COMPONENT_WIDTH +: COMPONENT_WIDTH]));
      a = d[DW-1] ? DW'(-d) : d;
      s = s + (DSQ+2)'(a) * (DSQ+2)'(a);
    end
    dist_c = (s[DSQ+1:DSQ] != 2'b00) ? '1 : s[DSQ-1:0];
  end

  // scan entries, keep earliest minimum
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_idx_r <= '0;
      first_r  <= 1'b1;
    end
    if (cmd.scan_rd) begin
      rd_idx_r  <= rd_idx_r + 1'b1;
      acc_idx_r <= rd_idx_r[AW-1:0];
    end
    if (cmd.scan_acc) begin
      first_r <= 1'b0;
      if (first_r || dist_c < best_d_r) begin
        best_d_r   <= dist_c;
        best_idx_r <= acc_idx_r;
      end
    end
  end

  // square root, one result bit per cycle
  always_ff @(posedge clk) begin
    logic [DSQ-1:0] bitv, trial;
    if (cmd.sqrt_init) begin
      sq_rem_r  <= best_d_r;
      sq_root_r <= '0;
      sq_cnt_r  <= '0;
    end else if (cmd.sqrt_step) begin
      bitv  = DSQ'(1) << (62 - 2 * sq_cnt_r);
      trial = sq_root_r + bitv;
      if (sq_rem_r >= trial) begin
        sq_rem_r  <= sq_rem_r - trial;
        sq_root_r <= (sq_root_r >> 1) + bitv;
      end else begin
        sq_root_r <= sq_root_r >> 1;
      end
      sq_cnt_r <= sq_cnt_r + 1'b1;
    end
  end

  // blend one component per cycle with floor and saturate
  always_ff @(posedge clk) begin
    logic signed [DW-1:0] p, m, diff;
    logic signed [PW-1:0] prod;
    logic signed [DW+1:0] r;
    if (cmd.sqrt_init) bl_k_r <= '0;
    else if (cmd.blend) begin
      p    = DW'($signed(vec_r[bl_k_r]));
      m    = DW'($signed(rd_data_r[bl_k_r*COMPONENT_WIDTH +: COMPONENT_WIDTH]));
      diff = m - p;
      prod = $signed({1'b0, move_rate}) * PW'(diff);
      r    = (DW+2)'(p) + (DW+2)'(prod >>> 8);
      if (r > CMAX)      blend_r[bl_k_r] <= COMPONENT_WIDTH'(CMAX);
      else if (r < CMIN) blend_r[bl_k_r] <= COMPONENT_WIDTH'(CMIN);
      else               blend_r[bl_k_r] <= COMPONENT_WIDTH'(r);
      bl_k_r <= bl_k_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    logic signed [RW+1:0] w;
    if (cmd.out_load) begin
      res_empty   <= (count_r == '0);
      res_dropped <= sticky_r;
      if (count_r == '0) begin
        res_vec    <= vec_r;
        res_weight <= wt_r;
        res_index  <= '0;
      end else begin
        res_vec   <= blend_r;
        res_index <= pnmu_pkg::INDEX_WIDTH'(best_idx_r);
        if (weight_enable) begin
          w = (RW+2)'(max_distance) - (RW+2)'(sq_root_r);
          if (w < -(RW+2)'(64'sd1 <<< (WW-1))) res_weight <= {1'b1, {(WW-1){1'b0}}};
          else                                  res_weight <= WW'(w);
        end else begin
          res_weight <= wt_r;
        end
      end
    end
  end

  assign stat.act_clear  = (act_r == pnmu_pkg::ACT_CLEAR);
  assign stat.act_append = (act_r == pnmu_pkg::ACT_APPEND);
  assign stat.act_update = (act_r == pnmu_pkg::ACT_UPDATE);
  assign stat.empty      = (count_r == '0);
  assign stat.scan_last  = (rd_idx_r == count_r);
  assign stat.sqrt_done  = (sq_cnt_r == 6'd31);
  assign stat.blend_done = (bl_k_r == 2'd3);

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP) else $error("count above capacity");
  a_drop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_append && count_r == CAP) |=> sticky_r) else $error("drop not flagged");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rd |-> rd_idx_r < count_r) else $error("scan past fill");

endmodule

### src/particle_nearest_measurement_update.sv
// Nearest-measurement update for a 4-D particle filter. Each input beat is
// one action: clear, append or update. Clear and append return nothing. For
// an update the store memory is scanned one entry per cycle, the square
// root resolves one bit per cycle, and the four components blend one per
// cycle through a shared multiplier.
// tdata, low bit up:
// in: vec_x, vec_y, vec_vx, vec_vy, in_weight (tuser = action);
// out: out_x, out_y, out_vx, out_vy, out_weight, nearest_index,
// no_measurement, dropped_flag.
module particle_nearest_measurement_update #(
  parameter int MAX_MEASUREMENTS = pnmu_pkg::MAX_MEASUREMENTS_DEF,
  parameter int COMPONENT_WIDTH  = pnmu_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // vec_x, vec_y, vec_vx, vec_vy, in_weight
  input  logic [((4*COMPONENT_WIDTH+pnmu_pkg::WEIGHT_WIDTH+7)/8)*8-1:0] in_tdata,
  // action
  input  logic [1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // out_x, out_y, out_vx, out_vy, out_weight, nearest_index, no_measurement, dropped_flag
  output logic [((4*COMPONENT_WIDTH+pnmu_pkg::WEIGHT_WIDTH+8+7)/8)*8-1:0] out_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [pnmu_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [pnmu_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam int VW  = 4 * COMPONENT_WIDTH;
  localparam int WW  = pnmu_pkg::WEIGHT_WIDTH;
  localparam int OTW = ((VW + WW + 8 + 7) / 8) * 8;

  pnmu_pkg::cmd_t  cmd;
  pnmu_pkg::stat_t stat;
  logic [pnmu_pkg::RATE_WIDTH-1:0] move_rate_r;
  logic                            weight_enable_r;
  logic [pnmu_pkg::MAXD_WIDTH-1:0] max_distance_r;
  logic [3:0][COMPONENT_WIDTH-1:0] res_vec;
  logic [WW-1:0]                   res_weight;
  logic [pnmu_pkg::INDEX_WIDTH-1:0] res_index;
  logic res_empty, res_dropped;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_rate_r     <= pnmu_pkg::RATE_WIDTH'(26);
      weight_enable_r <= 1'b1;
      max_distance_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pnmu_pkg::REG_MOVE_RATE:     move_rate_r <= cfg_data[pnmu_pkg::RATE_WIDTH-1:0];
        pnmu_pkg::REG_WEIGHT_ENABLE: weight_enable_r <= cfg_data[0];
        pnmu_pkg::REG_MAX_DISTANCE:  max_distance_r <= cfg_data[pnmu_pkg::MAXD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  pnmu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .stat(stat), .cmd(cmd)
  );

  pnmu_datapath #(
    .MAX_MEASUREMENTS(MAX_MEASUREMENTS), .COMPONENT_WIDTH(COMPONENT_WIDTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_action(in_tuser),
    .in_vec(in_tdata[VW-1:0]),
    .in_weight(in_tdata[VW +: WW]),
    .move_rate(move_rate_r), .weight_enable(weight_enable_r),
    .max_distance(max_distance_r),
    .res_vec(res_vec), .res_weight(res_weight), .res_index(res_index),
    .res_empty(res_empty), .res_dropped(res_dropped)
  );

  assign out_tdata = OTW'({res_dropped, res_empty, res_index, res_weight, res_vec});

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CW        = pnmu_pkg::COMPONENT_WIDTH_DEF;
  localparam int DEPTH     = pnmu_pkg::MAX_MEASUREMENTS_DEF;
  localparam int WTW       = pnmu_pkg::WEIGHT_WIDTH;
  localparam int IN_W      = ((4*CW+WTW+7)/8)*8;
  localparam int OUT_W     = ((4*CW+WTW+8+7)/8)*8;
  localparam int IDLE_WAIT = 120;
  localparam int STALL_CAP = 2000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef logic signed [CW-1:0] comp_t;
  typedef logic signed [WTW-1:0] wgt_t;

  typedef struct {
    comp_t c [4];
    wgt_t  w;
    logic [pnmu_pkg::INDEX_WIDTH-1:0] idx;
    logic  empty;
    logic  dropped;
  } particle_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pnmu_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [pnmu_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;

  // predictor state
  comp_t meas_store [DEPTH][4];
  int unsigned meas_count;
  logic overflow_seen;
  int unsigned rate_cfg;
  logic weigh_cfg;
  int unsigned maxd_cfg;

  particle_res_t pending_updates [$];
  int errors;
  int quiet_cycles;
  bit out_no_stall;
  bit in_no_gap;
  int out_stall_left;

  particle_nearest_measurement_update u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic comp_t step_toward(comp_t p, comp_t m);
    longint prod;
    longint r;
    prod = longint'(rate_cfg) * (longint'(m) - longint'(p));
    r = longint'(p) + (prod >>> 8);
    if (r > 524287) r = 524287;
    if (r < -524288) r = -524288;
    return comp_t'(r);
  endfunction

  // apply one action to the predictor, queue a result for updates
  task automatic track_action(logic [1:0] act, comp_t v [4], wgt_t w);
    particle_res_t res;
    longint unsigned best_d;
    longint unsigned d;
    longint diff;
    longint wt;
    int best;
    case (act)
      pnmu_pkg::ACT_CLEAR: begin
        meas_count = 0;
        overflow_seen = 1'b0;
      end
      pnmu_pkg::ACT_APPEND: begin
        if (meas_count < DEPTH) begin
          meas_store[meas_count] = v;
          meas_count++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      pnmu_pkg::ACT_UPDATE: begin
        res.c = v;
        res.w = w;
        res.idx = '0;
        res.empty = (meas_count == 0);
        res.dropped = overflow_seen;
        if (meas_count != 0) begin
          best = 0;
          best_d = 0;
          for (int i = 0; i < meas_count; i++) begin
            d = 0;
            for (int k = 0; k < 4; k++) begin
              diff = longint'(v[k]) - longint'(meas_store[i][k]);
              d += longint'(diff * diff);
            end
            if (i == 0 || d < best_d) begin
              best_d = d;
              best = i;
            end
          end
          for (int k = 0; k < 4; k++) res.c[k] = step_toward(v[k], meas_store[best][k]);
          res.idx = best[pnmu_pkg::INDEX_WIDTH-1:0];
          if (weigh_cfg) begin
            wt = longint'(maxd_cfg) - longint'(floor_root(best_d));
            if (wt < -2097152) wt = -2097152;
            if (wt > 2097151) wt = 2097151;
            res.w = wgt_t'(wt);
          end
        end
        pending_updates.insert(pending_updates.size(), res);
      end
      default: ;
    endcase
  endtask

  task automatic send_item(logic [1:0] act, comp_t v [4], wgt_t w);
    int gap;
    gap = in_no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {{(IN_W-4*CW-WTW){1'b0}}, w, v[3], v[2], v[1], v[0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_action(act, v, w);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [pnmu_pkg::CFG_INDEX_WIDTH-1:0] idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      pnmu_pkg::REG_MOVE_RATE:     rate_cfg = val & 32'h1FF;
      pnmu_pkg::REG_WEIGHT_ENABLE: weigh_cfg = val[0];
      pnmu_pkg::REG_MAX_DISTANCE:  maxd_cfg = val & 32'h7FFFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(int unsigned rate, int unsigned weigh, int unsigned maxd);
    wait_idle();
    write_reg(pnmu_pkg::REG_MOVE_RATE, rate);
    write_reg(pnmu_pkg::REG_WEIGHT_ENABLE, weigh);
    write_reg(pnmu_pkg::REG_MAX_DISTANCE, maxd);
  endtask

  task automatic report_mismatch(string field, longint exp_v, longint got_v);
    $display("mismatch %s: expected %0d got %0d at %0t", field, exp_v, got_v, $realtime);
    errors++;
  endtask

  function automatic wgt_t rand_weight();
    return wgt_t'(longint'($urandom_range(0, 2621439)) - 2097152);
  endfunction

  task automatic send_vec(logic [1:0] act, int x, int y, int vx, int vy, wgt_t w);
    comp_t v [4];
    v[0] = comp_t'(x); v[1] = comp_t'(y); v[2] = comp_t'(vx); v[3] = comp_t'(vy);
    send_item(act, v, w);
  endtask

  // extremes, every action and each corner case by hand
  task automatic test_directed();
    send_vec(pnmu_pkg::ACT_UPDATE, 524287, -524288, 524287, -524288, -2097152);
    send_vec(ACT_UNUSED, 1, 2, 3, 4, 5);
    send_vec(pnmu_pkg::ACT_APPEND, 256, 0, 0, 0, 0);
    send_vec(pnmu_pkg::ACT_APPEND, -256, 0, 0, 0, 0);
    send_vec(pnmu_pkg::ACT_UPDATE, 0, 0, 0, 0, 524287);
    send_vec(pnmu_pkg::ACT_UPDATE, -300, 7, -9, 11, 100);
    send_vec(pnmu_pkg::ACT_CLEAR, 0, 0, 0, 0, 0);
    send_vec(pnmu_pkg::ACT_APPEND, 524287, 524287, 524287, 524287, 0);
    send_vec(pnmu_pkg::ACT_UPDATE, -524288, -524288, -524288, -524288, 0);
    set_regs(256, 1, 524287);
    send_vec(pnmu_pkg::ACT_UPDATE, -524288, 0, 524287, -1, 0);
    set_regs(511, 1, 0);
    send_vec(pnmu_pkg::ACT_UPDATE, -524288, -524288, -524288, -524288, 3);
    send_vec(pnmu_pkg::ACT_UPDATE, 0, 0, 0, 0, 3);
    set_regs(0, 0, 1000);
    send_vec(pnmu_pkg::ACT_UPDATE, 12345, -777, 42, -42, -2097152);
    send_vec(pnmu_pkg::ACT_CLEAR, 0, 0, 0, 0, 0);
    send_vec(pnmu_pkg::ACT_UPDATE, 5, 6, 7, 8, 524287);
  endtask

  function automatic comp_t rand_comp(comp_t base);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return comp_t'($urandom);
    if (r == 4) return ($urandom_range(0, 1)) ? comp_t'(524287) : comp_t'(-524288);
    return comp_t'(int'(base) + $urandom_range(0, 4096) - 2048);
  endfunction

  // mostly clear, fill measurements (now and then past capacity), then update particles near them
  task automatic test_random(int n_items);
    comp_t v [4];
    comp_t base [4];
    int sent;
    int n_app;
    int n_upd;
    logic [1:0] act;
    sent = 0;
    while (sent < n_items) begin
      in_no_gap = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 4; k++) base[k] = comp_t'($urandom);
      if ($urandom_range(0, 9) != 0) begin
        send_vec(pnmu_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, rand_weight());
        sent++;
      end
      n_app = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
      for (int i = 0; i < n_app; i++) begin
        for (int k = 0; k < 4; k++) v[k] = rand_comp(base[k]);
        send_item(pnmu_pkg::ACT_APPEND, v, rand_weight());
        sent++;
      end
      n_upd = $urandom_range(1, 8);
      for (int i = 0; i < n_upd; i++) begin
        for (int k = 0; k < 4; k++) v[k] = rand_comp(base[k]);
        act = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3)) : pnmu_pkg::ACT_UPDATE;
        send_item(act, v, rand_weight());
        sent++;
      end
    end
    in_no_gap = 1'b0;
  endtask

  // stall the result side at random, with stretches of none
  always @(posedge clk) begin
    if (out_no_stall) begin
      out_tready <= 1'b1;
    end else if (out_stall_left > 0) begin
      out_stall_left <= out_stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_stall_left <= pick_gap();
      out_tready <= 1'b1;
    end
  end

  // compare each result beat with the oldest predicted update
  always @(posedge clk) begin
    particle_res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_updates.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        errors++;
      end else begin
        exp_r = pending_updates.pop_front();
        if (out_tdata[19:0] !== exp_r.c[0])
          report_mismatch("out_x", exp_r.c[0], $signed(out_tdata[19:0]));
        if (out_tdata[39:20] !== exp_r.c[1])
          report_mismatch("out_y", exp_r.c[1], $signed(out_tdata[39:20]));
        if (out_tdata[59:40] !== exp_r.c[2])
          report_mismatch("out_vx", exp_r.c[2], $signed(out_tdata[59:40]));
        if (out_tdata[79:60] !== exp_r.c[3])
          report_mismatch("out_vy", exp_r.c[3], $signed(out_tdata[79:60]));
        if (out_tdata[101:80] !== exp_r.w)
          report_mismatch("out_weight", exp_r.w, $signed(out_tdata[101:80]));
        if (out_tdata[107:102] !== exp_r.idx)
          report_mismatch("nearest_index", exp_r.idx, out_tdata[107:102]);
        if (out_tdata[108] !== exp_r.empty)
          report_mismatch("no_measurement", exp_r.empty, out_tdata[108]);
        if (out_tdata[109] !== exp_r.dropped)
          report_mismatch("dropped_flag", exp_r.dropped, out_tdata[109]);
      end
    end
  end

  // end the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_CAP) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    quiet_cycles = 0;
    out_no_stall = 1'b0;
    in_no_gap = 1'b0;
    out_stall_left = 0;
    meas_count = 0;
    overflow_seen = 1'b0;
    rate_cfg = 26;
    weigh_cfg = 1'b1;
    maxd_cfg = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    set_regs(26, 1, 0);
    test_random(330);
    // hold the sender until the store of pending updates drains
    wait_idle();
    out_no_stall = 1'b1;
    test_random(250);
    out_no_stall = 1'b0;
    set_regs(256, 1, 524287);
    test_random(330);
    set_regs(511, 0, $urandom_range(0, 524287));
    test_random(330);
    set_regs(0, 1, $urandom_range(0, 524287));
    test_random(330);
    set_regs($urandom_range(0, 511), 1, $urandom_range(0, 524287));
    test_random(330);

    wait_idle();
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
src/pnmu_pkg.sv
src/pnmu_ctrl.sv
src/pnmu_datapath.sv
src/particle_nearest_measurement_update.sv
test/tb.sv
